### rtl/cmct_pkg.sv
// Package for the complex B * C^H matrix product core.
// Holds the shared types, widths and the saturation helper; no dependencies.
package cmct_pkg;
	localparam int unsigned DefaultDim = 3;
	localparam int unsigned DataW = 32;
	localparam int unsigned FracBits = 30;
	localparam int unsigned AccW = 40;

	typedef struct packed {
		logic signed [DataW-1:0] re;
		logic signed [DataW-1:0] im;
	} cplx_t;

	// Operation codes handed from the loader to the compute engine.
	typedef enum logic [1:0] {
		OP_FULL = 2'd0,
		OP_UNI3 = 2'd1,
		OP_UNI2 = 2'd2
	} op_t;

	// One matrix job: how to complete the result matrix.
	typedef struct packed {
		op_t op;
	} job_t;

	// Saturate a wide accumulator to 32 bits.
	function automatic logic signed [DataW-1:0] sat(input logic signed [AccW-1:0] v);
		logic signed [AccW-1:0] hi;
		logic signed [AccW-1:0] lo;
		hi = AccW'(signed'(33'sh0_7FFF_FFFF));
		lo = -AccW'(signed'(33'sh0_8000_0000));
		if (v > hi) begin
			sat = 32'sh7FFF_FFFF;
		end else if (v < lo) begin
			sat = 32'sh8000_0000;
		end else begin
			sat = v[DataW-1:0];
		end
	endfunction
endpackage

### rtl/cmct_loader.sv
// Front part: accepts element pairs, writes them into the B and C memories,
// and hands a job to the engine when a matrix completes. Uses cmct_pkg.
module cmct_loader #(
	parameter int unsigned Dim = cmct_pkg::DefaultDim,
	localparam int unsigned Elems = Dim * Dim,
	localparam int unsigned AddrW = $clog2(Elems)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  logic [31:0]           b_real,
	input  logic [31:0]           b_imag,
	input  logic [31:0]           c_real,
	input  logic [31:0]           c_imag,
	input  logic                  mode,
	input  logic                  bank_free,
	output logic                  wr_en,
	output logic [AddrW-1:0]      wr_addr,
	output cmct_pkg::cplx_t       wr_b,
	output cmct_pkg::cplx_t       wr_c,
	output logic                  job_valid,
	output cmct_pkg::job_t        job
);
	logic [AddrW-1:0] count_q;
	logic             accept;
	logic             last;

	// Block loading while the engine still reads the stores.
	assign full    = !bank_free;
	assign accept  = push && !full;
	assign last    = (count_q == AddrW'(Elems - 1));
	assign wr_en   = accept;
	assign wr_addr = count_q;
	assign wr_b    = '{re: b_real, im: b_imag};
	assign wr_c    = '{re: c_real, im: c_imag};
	assign job_valid = accept && last;

	// Classify the finished matrix.
	always_comb begin
		job.op = cmct_pkg::OP_FULL;
		if (mode && Dim == 3) begin
			job.op = cmct_pkg::OP_UNI3;
		end else if (mode && Dim == 2) begin
			job.op = cmct_pkg::OP_UNI2;
		end
	end

	// Advance the load position.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			count_q <= last ? '0 : count_q + 1'b1;
		end
	end
endmodule

### rtl/cmct_engine.sv
// Back part: owns B/C/product memories, runs one multiply at a time, and
// streams the result matrix through a one-entry output register. Uses cmct_pkg.
module cmct_engine #(
	parameter int unsigned Dim = cmct_pkg::DefaultDim,
	localparam int unsigned Elems = Dim * Dim,
	localparam int unsigned AddrW = $clog2(Elems),
	localparam int unsigned IdxW = (Dim > 1) ? $clog2(Dim) : 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [AddrW-1:0]      wr_addr,
	input  cmct_pkg::cplx_t       wr_b,
	input  cmct_pkg::cplx_t       wr_c,
	input  logic                  job_valid,
	input  cmct_pkg::job_t        job,
	output logic                  bank_free,
	output logic                  empty,
	input  logic                  pop,
	output logic [31:0]           a_real,
	output logic [31:0]           a_imag,
	output logic                  last_of_matrix
);
	localparam int unsigned AW = cmct_pkg::AccW;

	typedef enum logic [2:0] {
		ST_IDLE, ST_DOT, ST_CROSS, ST_FIN, ST_EMIT
	} state_t;

	cmct_pkg::cplx_t b_mem [Elems];
	cmct_pkg::cplx_t c_mem [Elems];
	cmct_pkg::cplx_t p_mem [Elems];

	state_t          state_q;
	cmct_pkg::op_t   op_q;
	logic [IdxW-1:0] i_q, j_q, m_q;
	logic [1:0]      t_q;        // product term within a step
	logic [1:0]      k_q;        // cross-product row element
	logic [2:0]      x_q;        // operand fetch phase for dot and cross products
	logic signed [AW-1:0] acc_re_q, acc_im_q;
	cmct_pkg::cplx_t b_s1, c_s1, opx_q, opy_q;
	logic [AddrW-1:0] emit_q;
	logic             out_v_q;
	cmct_pkg::cplx_t  out_q;
	logic             out_last_q;
	logic             rd_v_s1;
	logic             rd_last_s1;
	logic             emit_pend_q;
	cmct_pkg::cplx_t  p_rd_s1;

	// One multiplier shared over all terms.
	logic signed [31:0] mx, my;
	logic signed [63:0] prod;
	logic signed [AW-1:0] term;
	assign prod = mx * my;
	assign term = AW'(prod >>> cmct_pkg::FracBits);

	// Saturated element finished in the accumulators.
	cmct_pkg::cplx_t fin_val;
	assign fin_val = '{re: cmct_pkg::sat(acc_re_q), im: cmct_pkg::sat(acc_im_q)};

	// Store element loads.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			b_mem[wr_addr] <= wr_b;
			c_mem[wr_addr] <= wr_c;
		end
	end

	assign bank_free = (state_q == ST_IDLE);

	// Cross product operand indices: row k uses x*y - u*v.
	function automatic logic [AddrW-1:0] cx_idx(input logic [1:0] k, input logic [1:0] s);
		logic [3:0] v;
		v = 4'd0;
		unique case ({k, s})
			4'b00_00: v = 4'd1; 4'b00_01: v = 4'd5; 4'b00_10: v = 4'd2; 4'b00_11: v = 4'd4;
			4'b01_00: v = 4'd2; 4'b01_01: v = 4'd3; 4'b01_10: v = 4'd0; 4'b01_11: v = 4'd5;
			4'b10_00: v = 4'd0; 4'b10_01: v = 4'd4; 4'b10_10: v = 4'd1; 4'b10_11: v = 4'd3;
			default:  v = 4'd0;
		endcase
		cx_idx = AddrW'(v);
	endfunction

	// Select multiplier operands.
	always_comb begin
		mx = '0;
		my = '0;
		if (state_q == ST_DOT) begin
			unique case (t_q)
				2'd0: begin mx = b_s1.re; my = c_s1.re; end
				2'd1: begin mx = b_s1.im; my = c_s1.im; end
				2'd2: begin mx = b_s1.im; my = c_s1.re; end
				default: begin mx = b_s1.re; my = c_s1.im; end
			endcase
		end else begin
			unique case (t_q)
				2'd0: begin mx = opx_q.re; my = opy_q.re; end
				2'd1: begin mx = opx_q.im; my = opy_q.im; end
				2'd2: begin mx = opx_q.re; my = opy_q.im; end
				default: begin mx = opy_q.re; my = opx_q.im; end
			endcase
		end
	end

	logic [AddrW-1:0] row_base_i, row_base_j, p_idx;
	assign row_base_i = AddrW'(i_q * Dim + m_q);
	assign row_base_j = AddrW'(j_q * Dim + m_q);
	assign p_idx      = AddrW'(i_q * Dim + j_q);

	logic last_m, last_j, last_i;
	assign last_m = (m_q == IdxW'(Dim - 1));
	assign last_j = (j_q == IdxW'(Dim - 1));
	assign last_i = (op_q == cmct_pkg::OP_FULL) ? (i_q == IdxW'(Dim - 1)) : (i_q == IdxW'(
		(op_q == cmct_pkg::OP_UNI3) ? 1 : 0));

	logic out_take;
	assign out_take = out_v_q && pop;

	// Sequence compute and emit; hold state and registered outputs.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_q        <= cmct_pkg::OP_FULL;
			i_q <= '0; j_q <= '0; m_q <= '0; t_q <= '0; k_q <= '0; x_q <= '0;
			acc_re_q <= '0; acc_im_q <= '0;
			emit_q      <= '0;
			out_v_q     <= 1'b0;
			out_last_q  <= 1'b0;
			rd_v_s1     <= 1'b0;
			rd_last_s1  <= 1'b0;
			emit_pend_q <= 1'b0;
		end else begin
			rd_v_s1 <= 1'b0;
			if (out_take) begin
				out_v_q <= 1'b0;
			end
			// Output register refills from the product read stage.
			if (rd_v_s1) begin
				out_v_q    <= 1'b1;
				out_q      <= p_rd_s1;
				out_last_q <= rd_last_s1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (job_valid) begin
						op_q <= job.op;
						i_q <= '0; j_q <= '0; m_q <= '0; t_q <= '0;
						acc_re_q <= '0; acc_im_q <= '0;
						x_q <= '0;
						state_q <= ST_DOT;
					end
				end
				ST_DOT: begin
					// Fetch phase x_q==0 loads operands, then four terms.
					if (x_q == 3'd0) begin
						b_s1 <= b_mem[row_base_i];
						c_s1 <= c_mem[row_base_j];
						x_q  <= 3'd1;
					end else begin
						unique case (t_q)
							2'd0: acc_re_q <= acc_re_q + term;
							2'd1: acc_re_q <= acc_re_q + term;
							2'd2: acc_im_q <= acc_im_q + term;
							default: acc_im_q <= acc_im_q - term;
						endcase
						t_q <= t_q + 1'b1;
						if (t_q == 2'd3) begin
							x_q <= 3'd0;
							if (last_m) begin
								m_q <= '0;
								state_q <= ST_FIN;
							end else begin
								m_q <= m_q + 1'b1;
							end
						end
					end
				end
				ST_FIN: begin
					p_mem[p_idx] <= fin_val;
					acc_re_q <= '0; acc_im_q <= '0;
					if (!last_j) begin
						j_q <= j_q + 1'b1;
						state_q <= ST_DOT;
					end else if (!last_i) begin
						j_q <= '0;
						i_q <= i_q + 1'b1;
						state_q <= ST_DOT;
					end else if (op_q == cmct_pkg::OP_UNI3) begin
						k_q <= '0; x_q <= '0; t_q <= '0;
						state_q <= ST_CROSS;
					end else begin
						if (op_q == cmct_pkg::OP_UNI2) begin
							// Row 1 from row 0: a2 = -conj(a1), a3 = conj(a0);
							// a1 is the element finished this cycle.
							p_mem[AddrW'(2)] <= '{
								re: cmct_pkg::sat(-AW'(fin_val.re)),
								im: fin_val.im};
							p_mem[AddrW'(3)] <= '{re: p_mem[AddrW'(0)].re,
								im: cmct_pkg::sat(-AW'(p_mem[AddrW'(0)].im))};
						end
						emit_q <= '0;
						emit_pend_q <= 1'b1;
						state_q <= ST_EMIT;
					end
				end
				ST_CROSS: begin
					// Phase 0 fetches x,y, phase 1 runs four terms; phase 2 fetches u,v, phase 3 subtracts four terms; phase 4 stores.
					unique case (x_q)
						3'd0: begin opx_q <= p_mem[cx_idx(k_q, 2'd0)];
							opy_q <= p_mem[cx_idx(k_q, 2'd1)]; x_q <= 3'd1; t_q <= '0; end
						3'd1, 3'd3: begin
							unique case (t_q)
								2'd0: acc_re_q <= (x_q == 3'd1) ? acc_re_q + term : acc_re_q - term;
								2'd1: acc_re_q <= (x_q == 3'd1) ? acc_re_q - term : acc_re_q + term;
								2'd2: acc_im_q <= (x_q == 3'd1) ? acc_im_q + term : acc_im_q - term;
								default: acc_im_q <= (x_q == 3'd1) ? acc_im_q + term : acc_im_q - term;
							endcase
							t_q <= t_q + 1'b1;
							if (t_q == 2'd3) begin
								x_q <= x_q + 1'b1;
							end
						end
						3'd2: begin opx_q <= p_mem[cx_idx(k_q, 2'd2)];
							opy_q <= p_mem[cx_idx(k_q, 2'd3)]; x_q <= 3'd3; t_q <= '0; end
						default: begin
							p_mem[AddrW'(6 + k_q)] <= '{re: cmct_pkg::sat(acc_re_q),
								im: cmct_pkg::sat(-acc_im_q)};
							acc_re_q <= '0; acc_im_q <= '0;
							x_q <= '0;
							if (k_q == 2'd2) begin
								emit_q <= '0;
								emit_pend_q <= 1'b1;
								state_q <= ST_EMIT;
							end else begin
								k_q <= k_q + 1'b1;
							end
						end
					endcase
				end
				ST_EMIT: begin
					// Issue a read when the output register will be free.
					if (emit_pend_q && !rd_v_s1 && (!out_v_q || out_take)) begin
						p_rd_s1    <= p_mem[emit_q];
						rd_v_s1    <= 1'b1;
						rd_last_s1 <= (emit_q == AddrW'(Elems - 1));
						if (emit_q == AddrW'(Elems - 1)) begin
							emit_pend_q <= 1'b0;
						end else begin
							emit_q <= emit_q + 1'b1;
						end
					end
					if (!emit_pend_q && !rd_v_s1) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign empty          = !out_v_q;
	assign a_real         = out_q.re;
	assign a_imag         = out_q.im;
	assign last_of_matrix = out_last_q;
endmodule

### rtl/complex_matmul_conj_transpose_core.sv
// Top level of the complex B * C^H matrix product core.
// Uses cmct_pkg, cmct_loader and cmct_engine.
//
// Input channel: push/full with b_real, b_imag, c_real, c_imag; one transfer
// per element, row-major, Dim*Dim transfers per matrix. Result channel:
// empty/pop with a_real, a_imag, last_of_matrix; Dim*Dim transfers per
// matrix, last_of_matrix set on the final one.
// unitary_wr/unitary_data set the unitary completion mode; the user must write
// it only while idle, which the block does not enforce. Loading takes one
// element per cycle while the engine is idle. The loader passes each finished
// matrix to the engine, whose single shared 32x32 multiplier runs each inner
// step as an operand fetch and four products, then stores each element.
// Unitary mode at size three computes only the top two rows and builds the
// last from their cross products. Each result read waits for the previous
// one to reach the output register. full stays high from the last element
// of a matrix until its final result enters the output register.
// Reset clears the load count, mode and all handshake state; stores need
// no clearing. A stalled receiver (pop low) holds the result register and
// pauses emission without losing data.
module complex_matmul_conj_transpose_core #(
	parameter int unsigned MatrixDim = cmct_pkg::DefaultDim,
	localparam int unsigned Elems = MatrixDim * MatrixDim,
	localparam int unsigned AddrW = $clog2(Elems)
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [31:0] b_real,
	input  logic [31:0] b_imag,
	input  logic [31:0] c_real,
	input  logic [31:0] c_imag,
	output logic        empty,
	input  logic        pop,
	output logic [31:0] a_real,
	output logic [31:0] a_imag,
	output logic        last_of_matrix,
	input  logic        unitary_wr,
	input  logic        unitary_data
);
	logic             mode_q;
	logic             bank_free, wr_en, job_valid;
	logic [AddrW-1:0] wr_addr;
	cmct_pkg::cplx_t  wr_b, wr_c;
	cmct_pkg::job_t   job;

	// Hold the mode register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
		end else if (unitary_wr) begin
			mode_q <= unitary_data;
		end
	end

	cmct_loader #(.Dim(MatrixDim)) u_loader (
		.clk, .arst_n, .push, .full, .b_real, .b_imag, .c_real, .c_imag,
		.mode(mode_q), .bank_free, .wr_en, .wr_addr, .wr_b, .wr_c,
		.job_valid, .job
	);

	cmct_engine #(.Dim(MatrixDim)) u_engine (
		.clk, .arst_n, .wr_en, .wr_addr, .wr_b, .wr_c, .job_valid, .job,
		.bank_free, .empty, .pop, .a_real, .a_imag, .last_of_matrix
	);
endmodule
